### hdl/vkr_pkg.sv
`default_nettype none
package vkr_pkg;

   // alphabet and character codes
   localparam int LETTERS = 26;
   localparam int LETTER_BITS = 5;
   localparam int KEY_POS_BITS = 5;
   localparam int KEY_LEN_BITS = 6;
   localparam int BYTE_BITS = 8;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CASE_GAP = 8'h20;
   localparam logic [7:0] CHAR_LOWER_A = CHAR_UPPER_A + CASE_GAP;
   localparam logic [7:0] CHAR_LOWER_Z = CHAR_UPPER_Z + CASE_GAP;
   localparam logic [LETTER_BITS-1:0] LAST_STEP = LETTER_BITS'(LETTERS - 1);

   // default sizes
   localparam int KEY_MAX_DEFAULT = 32;
   localparam int COUNT_BITS_DEFAULT = 20;
   localparam int REF_BITS_DEFAULT = 16;

   // request codes
   typedef enum logic [1:0] {
      REQ_LOAD_REF = 2'd0,
      REQ_TEXT     = 2'd1,
      REQ_SOLVE    = 2'd2,
      REQ_NONE     = 2'd3
   } req_code_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_INC,
      ST_LOAD,
      ST_LOAD_WAIT,
      ST_TOTAL,
      ST_SCORE,
      ST_DRAIN,
      ST_MIN,
      ST_EMIT
   } state_type;

   // controls shared by every cell of the ring
   typedef struct packed {
      logic load;
      logic rotate;
      logic acc_clr;
      logic acc_en;
      logic min_en;
   } cell_ctl_type;

endpackage
`default_nettype wire

### hdl/vkr_ram.sv
`default_nettype none
module vkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### hdl/vkr_cell.sv
`default_nettype none
module vkr_cell #(
   parameter int COUNT_BITS = vkr_pkg::COUNT_BITS_DEFAULT,
   parameter int REF_BITS = vkr_pkg::REF_BITS_DEFAULT,
   parameter int CELL_INDEX = 0,
   localparam int TB = COUNT_BITS + 5,
   localparam int DW = REF_BITS + TB,
   localparam int SQW = 2 * DW,
   localparam int SCW = SQW + 5
) (
   input  logic                           clock,
   input  vkr_pkg::cell_ctl_type          ctl,
   input  logic [COUNT_BITS-1:0]          load_count,
   input  logic [COUNT_BITS-1:0]          right_count,
   input  logic [DW-1:0]                  want,
   input  logic [SCW-1:0]                 in_score,
   input  logic [vkr_pkg::LETTER_BITS-1:0] in_shift,
   output logic [COUNT_BITS-1:0]          count,
   output logic [SCW-1:0]                 min_score,
   output logic [vkr_pkg::LETTER_BITS-1:0] min_shift
);

   localparam int H = (DW + 1) / 2;
   localparam int HL = DW - H;

   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [DW-1:0] have;
   logic [DW-1:0] d_ff, d_in;
   logic [H-1:0] d_lo;
   logic [HL-1:0] d_hi;
   logic [2*HL-1:0] hh_ff;
   logic [HL+H-1:0] hl_ff;
   logic [2*H-1:0] ll_ff;
   logic [SQW-1:0] sq_ff, sq_in;
   logic [SCW-1:0] acc_ff, acc_in;
   logic [SCW-1:0] min_score_ff, min_score_in;
   logic [vkr_pkg::LETTER_BITS-1:0] min_shift_ff, min_shift_in;
   logic [vkr_pkg::LETTER_BITS-1:0] own_shift;

   assign own_shift = vkr_pkg::LETTER_BITS'(CELL_INDEX);

   // count held in the ring, handed left on each rotation
   always_comb begin
      if (ctl.load) begin
         count_in = load_count;
      end else if (ctl.rotate) begin
         count_in = right_count;
      end else begin
         count_in = count_ff;
      end
   end

   // absolute difference against the broadcast expected value
   assign have = DW'({count_ff, {REF_BITS{1'b0}}});
   assign d_in = (have >= want) ? (have - want) : (want - have);
   assign d_lo = d_ff[H-1:0];
   assign d_hi = d_ff[DW-1:H];

   // square rebuilt from the partial products
   assign sq_in = (SQW'(hh_ff) << (2 * H)) + (SQW'(hl_ff) << (H + 1)) + SQW'(ll_ff);

   // score accumulator
   always_comb begin
      if (ctl.acc_clr) begin
         acc_in = '0;
      end else if (ctl.acc_en) begin
         acc_in = acc_ff + SCW'(sq_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   // running minimum along the chain, earlier shift wins ties
   always_comb begin
      min_score_in = min_score_ff;
      min_shift_in = min_shift_ff;
      if (ctl.min_en) begin
         if ((CELL_INDEX == 0) || (acc_ff < in_score)) begin
            min_score_in = acc_ff;
            min_shift_in = own_shift;
         end else begin
            min_score_in = in_score;
            min_shift_in = in_shift;
         end
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      d_ff <= d_in;
      hh_ff <= (2*HL)'(d_hi) * (2*HL)'(d_hi);
      hl_ff <= (HL+H)'(d_hi) * (HL+H)'(d_lo);
      ll_ff <= (2*H)'(d_lo) * (2*H)'(d_lo);
      sq_ff <= sq_in;
      acc_ff <= acc_in;
      min_score_ff <= min_score_in;
      min_shift_ff <= min_shift_in;
   end

   assign count = count_ff;
   assign min_score = min_score_ff;
   assign min_shift = min_shift_ff;

endmodule
`default_nettype wire

### hdl/vigenere_key_recovery_unit.sv
`default_nettype none
// channel   direction  ports                                   handshake
// req       in         req_type req_text_byte req_ref_*        req_valid / req_ready
// rsp       out        rsp_key_position rsp_key_shift rsp_last rsp_valid / rsp_ready
// csr       in         csr_wr_data (key_length)                csr_wr_en, no wait
//
// reference load, non-letter or unused item: accepted in idle; letter: then read and
//   write back one histogram RAM.
// solve: per key column, load the column into the cell ring, sum the total over
//   the 26 letters, score every shift through the ring, drain the score pipeline
//   and run the minimum chain; then clear the histogram RAMs one column per cycle.
// after reset the same clearing pass of all KEY_MAX columns runs; req_ready is low.
// a result waiting on rsp_ready stalls the next result and the rest of the solve.
module vigenere_key_recovery_unit #(
   parameter int KEY_MAX = vkr_pkg::KEY_MAX_DEFAULT,
   parameter int COUNT_BITS = vkr_pkg::COUNT_BITS_DEFAULT,
   parameter int REF_BITS = vkr_pkg::REF_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_text_byte,
   input  logic [4:0]  req_ref_index,
   input  logic [15:0] req_ref_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_key_position,
   output logic [4:0]  rsp_key_shift,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [5:0]  csr_wr_data
);

   localparam int NL = vkr_pkg::LETTERS;
   localparam int LB = vkr_pkg::LETTER_BITS;
   localparam int COL_BITS = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int LEN_BITS = $clog2(KEY_MAX + 1);
   localparam int TB = COUNT_BITS + 5;
   localparam int TH = (TB + 1) / 2;
   localparam int DW = REF_BITS + TB;
   localparam int SCW = 2 * DW + 5;
   localparam logic [COL_BITS-1:0] LAST_COL = COL_BITS'(KEY_MAX - 1);

   vkr_pkg::state_type state_ff, state_in;

   logic [vkr_pkg::KEY_LEN_BITS-1:0] key_length_ff;
   logic [LEN_BITS-1:0] len_w;
   logic [COL_BITS-1:0] pos_ff, pos_in, eff_pos, pos_next;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [COL_BITS-1:0] clr_ff, clr_in;
   logic [LB-1:0] step_ff, step_in;
   logic [LB-1:0] inc_letter_ff;
   logic [COL_BITS-1:0] inc_addr_ff;
   logic [REF_BITS-1:0] ref_ff [NL];
   logic [TB-1:0] total_ff, total_in;
   logic [REF_BITS+TH-1:0] p_lo_ff;
   logic [REF_BITS+TB-TH-1:0] p_hi_ff;
   logic [DW-1:0] want_ff;
   logic [4:0] vld_ff;

   logic req_fire, is_upper, is_lower, is_letter, is_last, emit_fire, issue;
   logic [LB-1:0] letter;
   vkr_pkg::req_code_type req_code;

   logic [NL-1:0] ram_we;
   logic [COL_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [COUNT_BITS-1:0] ram_wr_data, inc_old;
   logic [COUNT_BITS-1:0] ram_rdata [NL];
   logic [COUNT_BITS-1:0] cell_count [NL];
   logic [SCW-1:0] cell_score [NL];
   logic [LB-1:0] cell_shift [NL];
   vkr_pkg::cell_ctl_type ctl;

   logic rsp_valid_ff, rsp_last_ff;
   logic [4:0] rsp_key_position_ff, rsp_key_shift_ff;

   // active key length, clamped to 1..KEY_MAX
   always_comb begin
      if (key_length_ff == '0) begin
         len_w = LEN_BITS'(1);
      end else if ({1'b0, key_length_ff} > 7'(KEY_MAX)) begin
         len_w = LEN_BITS'(KEY_MAX);
      end else begin
         len_w = LEN_BITS'(key_length_ff);
      end
   end

   // input decode
   assign req_code = vkr_pkg::req_code_type'(req_type);
   assign req_fire = req_valid && req_ready;
   assign is_upper = (req_text_byte >= vkr_pkg::CHAR_UPPER_A) &&
                     (req_text_byte <= vkr_pkg::CHAR_UPPER_Z);
   assign is_lower = (req_text_byte >= vkr_pkg::CHAR_LOWER_A) &&
                     (req_text_byte <= vkr_pkg::CHAR_LOWER_Z);
   assign is_letter = is_upper || is_lower;
   assign letter = is_upper ? LB'(req_text_byte - vkr_pkg::CHAR_UPPER_A)
                            : LB'(req_text_byte - vkr_pkg::CHAR_LOWER_A);

   // column of the next letter
   assign eff_pos = (LEN_BITS'(pos_ff) >= len_w) ? '0 : pos_ff;
   assign pos_next = (((LEN_BITS+1)'(eff_pos) + (LEN_BITS+1)'(1)) >= (LEN_BITS+1)'(len_w))
                     ? '0 : COL_BITS'(eff_pos + 1'b1);

   assign is_last = ((LEN_BITS+1)'(col_ff) + (LEN_BITS+1)'(1)) == (LEN_BITS+1)'(len_w);
   assign emit_fire = (state_ff == vkr_pkg::ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign inc_old = ram_rdata[inc_letter_ff];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vkr_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_COL) state_in = vkr_pkg::ST_IDLE;
         end
         vkr_pkg::ST_IDLE: begin
            if (req_valid) begin
               if ((req_code == vkr_pkg::REQ_TEXT) && is_letter) begin
                  state_in = vkr_pkg::ST_INC;
               end else if (req_code == vkr_pkg::REQ_SOLVE) begin
                  state_in = vkr_pkg::ST_LOAD;
               end
            end
         end
         vkr_pkg::ST_INC:       state_in = vkr_pkg::ST_IDLE;
         vkr_pkg::ST_LOAD:      state_in = vkr_pkg::ST_LOAD_WAIT;
         vkr_pkg::ST_LOAD_WAIT: state_in = vkr_pkg::ST_TOTAL;
         vkr_pkg::ST_TOTAL: begin
            if (step_ff == vkr_pkg::LAST_STEP) state_in = vkr_pkg::ST_SCORE;
         end
         vkr_pkg::ST_SCORE: begin
            if (step_ff == vkr_pkg::LAST_STEP) state_in = vkr_pkg::ST_DRAIN;
         end
         vkr_pkg::ST_DRAIN: begin
            if (vld_ff == '0) state_in = vkr_pkg::ST_MIN;
         end
         vkr_pkg::ST_MIN: begin
            if (step_ff == vkr_pkg::LAST_STEP) state_in = vkr_pkg::ST_EMIT;
         end
         vkr_pkg::ST_EMIT: begin
            if (emit_fire) state_in = is_last ? vkr_pkg::ST_CLEAR : vkr_pkg::ST_LOAD;
         end
         default: state_in = vkr_pkg::ST_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      ram_we = '0;
      ram_wr_addr = clr_ff;
      ram_wr_data = '0;
      ram_rd_addr = eff_pos;
      issue = 1'b0;
      ctl = '0;
      case (state_ff)
         vkr_pkg::ST_CLEAR: begin
            ram_we = '1;
         end
         vkr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         vkr_pkg::ST_INC: begin
            ram_we = NL'(1) << inc_letter_ff;
            ram_wr_addr = inc_addr_ff;
            ram_wr_data = (inc_old == '1) ? inc_old : inc_old + 1'b1;
         end
         vkr_pkg::ST_LOAD: begin
            ram_rd_addr = col_ff;
         end
         vkr_pkg::ST_LOAD_WAIT: begin
            ctl.load = 1'b1;
            ctl.acc_clr = 1'b1;
         end
         vkr_pkg::ST_TOTAL: begin
            ctl.rotate = 1'b1;
         end
         vkr_pkg::ST_SCORE: begin
            issue = 1'b1;
            ctl.rotate = vld_ff[1];
            ctl.acc_en = vld_ff[4];
         end
         vkr_pkg::ST_DRAIN: begin
            ctl.rotate = vld_ff[1];
            ctl.acc_en = vld_ff[4];
         end
         vkr_pkg::ST_MIN: begin
            ctl.min_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // counters and column state
   always_comb begin
      case (state_ff)
         vkr_pkg::ST_TOTAL, vkr_pkg::ST_SCORE, vkr_pkg::ST_MIN: begin
            step_in = (step_ff == vkr_pkg::LAST_STEP) ? '0 : step_ff + 1'b1;
         end
         default: step_in = '0;
      endcase
      clr_in = (state_ff == vkr_pkg::ST_CLEAR) ? clr_ff + 1'b1 : '0;
      col_in = col_ff;
      if (req_fire && (req_code == vkr_pkg::REQ_SOLVE)) begin
         col_in = '0;
      end else if (emit_fire && !is_last) begin
         col_in = col_ff + 1'b1;
      end
      pos_in = pos_ff;
      if (req_fire && (req_code == vkr_pkg::REQ_SOLVE)) begin
         pos_in = '0;
      end else if (req_fire && (req_code == vkr_pkg::REQ_TEXT) && is_letter) begin
         pos_in = pos_next;
      end
      if (state_ff == vkr_pkg::ST_LOAD_WAIT) begin
         total_in = TB'(1);
      end else if (state_ff == vkr_pkg::ST_TOTAL) begin
         total_in = total_ff + TB'(cell_count[0]);
      end else begin
         total_in = total_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vkr_pkg::ST_CLEAR;
         key_length_ff <= vkr_pkg::KEY_LEN_BITS'(1);
         pos_ff <= '0;
         col_ff <= '0;
         clr_ff <= '0;
         step_ff <= '0;
         vld_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) key_length_ff <= csr_wr_data;
         pos_ff <= pos_in;
         col_ff <= col_in;
         clr_ff <= clr_in;
         step_ff <= step_in;
         vld_ff <= {vld_ff[3:0], issue};
         if (emit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire && (req_code == vkr_pkg::REQ_LOAD_REF) &&
          (req_ref_index < LB'(NL))) begin
         ref_ff[req_ref_index] <= REF_BITS'(req_ref_value);
      end
      inc_letter_ff <= letter;
      inc_addr_ff <= eff_pos;
      total_ff <= total_in;
      // expected value ref[j] * total in two partial products
      p_lo_ff <= (REF_BITS+TH)'(ref_ff[step_ff]) * (REF_BITS+TH)'(total_ff[TH-1:0]);
      p_hi_ff <= (REF_BITS+TB-TH)'(ref_ff[step_ff]) *
                 (REF_BITS+TB-TH)'(total_ff[TB-1:TH]);
      want_ff <= DW'(p_lo_ff) + (DW'(p_hi_ff) << TH);
      if (emit_fire) begin
         rsp_key_position_ff <= 5'(col_ff);
         rsp_key_shift_ff <= cell_shift[NL-1];
         rsp_last_ff <= is_last;
      end
   end

   // one histogram RAM per letter, the ring of cells
   for (genvar s = 0; s < NL; s++) begin : g_lane
      vkr_ram #(
         .WIDTH (COUNT_BITS),
         .DEPTH (KEY_MAX)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we[s]),
         .wr_addr (ram_wr_addr),
         .wr_data (ram_wr_data),
         .rd_addr (ram_rd_addr),
         .rd_data (ram_rdata[s])
      );

      vkr_cell #(
         .COUNT_BITS (COUNT_BITS),
         .REF_BITS   (REF_BITS),
         .CELL_INDEX (s)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .load_count  (ram_rdata[s]),
         .right_count (cell_count[(s + 1) % NL]),
         .want        (want_ff),
         .in_score    (cell_score[(s + NL - 1) % NL]),
         .in_shift    (cell_shift[(s + NL - 1) % NL]),
         .count       (cell_count[s]),
         .min_score   (cell_score[s]),
         .min_shift   (cell_shift[s])
      );
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_key_position = rsp_key_position_ff;
   assign rsp_key_shift = rsp_key_shift_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTHESIS
   // an increment write always follows an accepted text item
   assert property (@(posedge clock) disable iff (reset)
      state_ff == vkr_pkg::ST_INC |-> $past(req_valid && req_ready))
      else $error("increment without accepted item");

   // the last flag marks the final key column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_key_position_ff == 5'(len_w - 1'b1))
      else $error("last flag on wrong column");

   // accumulation only happens while scoring or draining
   assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (state_ff == vkr_pkg::ST_SCORE || state_ff == vkr_pkg::ST_DRAIN))
      else $error("score pipeline active outside scoring");

   // chosen shift is a letter
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_key_shift_ff < 5'(NL))
      else $error("shift out of range");
`endif

endmodule
`default_nettype wire

### sim/vigenere_key_recovery_unit_tb.sv
`default_nettype none
module vigenere_key_recovery_unit_tb;

   localparam int LETTERS = vkr_pkg::LETTERS;
   localparam int KEY_COLS = 32;
   localparam int COUNT_MAX = (1 << 20) - 1;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 200;
   localparam int TARGET_ITEMS = 470;
   localparam int DIRECTED_ROWS = 19;

   typedef struct {
      logic [4:0] key_position;
      logic [4:0] shift;
      logic       last;
   } key_result_type;

   typedef struct {
      vkr_pkg::req_code_type kind;
      logic [7:0]   text;
      logic [4:0]   index;
      logic [15:0]  value;
      bit           typed;
      logic [4:0]   shift;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = vkr_pkg::REQ_NONE;
   logic [7:0]  req_text_byte = '0;
   logic [4:0]  req_ref_index = '0;
   logic [15:0] req_ref_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_key_position;
   logic [4:0]  rsp_key_shift;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic [5:0]  csr_wr_data = '0;

   // shadow state of the block
   logic [19:0] column_counts [KEY_COLS][LETTERS];
   logic [15:0] freq_table [LETTERS];
   int unsigned next_column;
   logic [5:0]  key_length_reg;

   key_result_type shifts_due[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int solves_sent = 0;
   int stall_count = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;

   vigenere_key_recovery_unit u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_text_byte(req_text_byte),
      .req_ref_index(req_ref_index),
      .req_ref_value(req_ref_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_key_position(rsp_key_position),
      .rsp_key_shift(rsp_key_shift),
      .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   function automatic int unsigned columns_in_use();
      if (key_length_reg == 0) return 1;
      if (key_length_reg > KEY_COLS) return KEY_COLS;
      return key_length_reg;
   endfunction

   // shift whose rotated histogram is closest to the frequency table
   function automatic logic [4:0] closest_shift(input int unsigned col);
      logic [63:0]  total;
      logic [63:0]  have;
      logic [63:0]  want;
      logic [63:0]  diff;
      logic [127:0] score;
      logic [127:0] low_score;
      logic [4:0]   best;
      total = 64'd1;
      best = '0;
      low_score = '0;
      for (int j = 0; j < LETTERS; j++) total += 64'(column_counts[col][j]);
      for (int s = 0; s < LETTERS; s++) begin
         score = '0;
         for (int j = 0; j < LETTERS; j++) begin
            have = 64'(column_counts[col][(j + s) % LETTERS]) << 16;
            want = 64'(freq_table[j]) * total;
            diff = (have >= want) ? have - want : want - have;
            score += 128'(diff) * 128'(diff);
         end
         if (s == 0 || score < low_score) begin
            low_score = score;
            best = 5'(s);
         end
      end
      return best;
   endfunction

   // update shadow state for one accepted item, queue the key letters it yields
   task automatic track_item(input vkr_pkg::req_code_type kind, input logic [7:0] text,
                             input logic [4:0] index, input logic [15:0] value);
      int unsigned len;
      logic [7:0] c;
      key_result_type r;
      len = columns_in_use();
      case (kind)
         vkr_pkg::REQ_LOAD_REF: begin
            if (index < LETTERS) freq_table[index] = value;
         end
         vkr_pkg::REQ_TEXT: begin
            c = text;
            if (c >= vkr_pkg::CHAR_LOWER_A && c <= vkr_pkg::CHAR_LOWER_Z)
               c = c - vkr_pkg::CASE_GAP;
            if (c >= vkr_pkg::CHAR_UPPER_A && c <= vkr_pkg::CHAR_UPPER_Z) begin
               if (next_column >= len) next_column = 0;
               if (column_counts[next_column][c - vkr_pkg::CHAR_UPPER_A] != COUNT_MAX)
                  column_counts[next_column][c - vkr_pkg::CHAR_UPPER_A]++;
               next_column = (next_column + 1 >= len) ? 0 : next_column + 1;
            end
         end
         vkr_pkg::REQ_SOLVE: begin
            for (int unsigned col = 0; col < len; col++) begin
               r.key_position = 5'(col);
               r.shift = closest_shift(col);
               r.last = (col + 1 == len);
               shifts_due.push_back(r);
            end
            foreach (column_counts[k, j]) column_counts[k][j] = '0;
            next_column = 0;
         end
         default: ;
      endcase
   endtask

   // present one item and hold it until accepted
   task automatic send_item(input vkr_pkg::req_code_type kind, input logic [7:0] text,
                            input logic [4:0] index, input logic [15:0] value);
      int gap;
      gap = req_gaps_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_text_byte <= text;
      req_ref_index <= index;
      req_ref_value <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (kind == vkr_pkg::REQ_SOLVE) solves_sent++;
      track_item(kind, text, index, value);
   endtask

   // let every key letter come out and the block go quiet
   task automatic drain();
      req_valid <= 1'b0;
      while (shifts_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key_length(input logic [5:0] len);
      csr_wr_en <= 1'b1;
      csr_wr_data <= len;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      key_length_reg = len;
   endtask

   // result side: random stalls before each item
   initial begin
      int n;
      @(negedge reset);
      forever begin
         n = rsp_stalls_on ? $urandom_range(0, 14) : 0;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // compare every accepted result with the oldest expectation
   always @(posedge clock) begin
      key_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (shifts_due.size() == 0) begin
            report($sformatf("unexpected result col %0d shift %0d",
                             rsp_key_position, rsp_key_shift));
         end else begin
            e = shifts_due.pop_front();
            if (rsp_key_position !== e.key_position)
               report($sformatf("key_position %0d, want %0d",
                                rsp_key_position, e.key_position));
            if (rsp_key_shift !== e.shift)
               report($sformatf("col %0d shift %0d, want %0d",
                                e.key_position, rsp_key_shift, e.shift));
            if (rsp_last !== e.last)
               report($sformatf("col %0d last %0b, want %0b",
                                e.key_position, rsp_last, e.last));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("vigenere_key_recovery_unit_tb: done, errors");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // stimulus
   initial begin
      stim_row_type rows [DIRECTED_ROWS];
      int english [LETTERS];
      string common_order;
      int plan [8];
      int unsigned key_shift [KEY_COLS];
      int unsigned gen_col;
      int unsigned len;
      int text_count;
      int shrink_at;
      int p;
      logic [7:0] ch;

      english = '{5374, 983, 1835, 2818, 8323, 1442, 1311, 3998, 4588, 98, 505, 2621,
                  1573, 4391, 4915, 1245, 66, 3932, 4129, 5964, 1835, 655, 1573, 98,
                  1311, 46};
      common_order = "ETAOINSHRDLCUMWFGYPBVKJXQZ";
      plan = '{0, 32, 63, 1, 33, 2, 31, 7};

      rows = '{
         '{vkr_pkg::REQ_SOLVE,    8'h00, 5'd0,  16'h0000, 1'b1, 5'd0},  // empty column
         '{vkr_pkg::REQ_LOAD_REF, 8'h00, 5'd26, 16'hffff, 1'b0, 5'd0},  // index out of range
         '{vkr_pkg::REQ_LOAD_REF, 8'h00, 5'd31, 16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_NONE,     8'hff, 5'd31, 16'hffff, 1'b0, 5'd0},  // unused code
         '{vkr_pkg::REQ_TEXT,     8'h41, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h5a, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h61, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h7a, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h40, 5'd0,  16'h0000, 1'b0, 5'd0},  // letter boundaries
         '{vkr_pkg::REQ_TEXT,     8'h5b, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h60, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h7b, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h00, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'hff, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_LOAD_REF, 8'h00, 5'd0,  16'hffff, 1'b0, 5'd0},  // value extremes
         '{vkr_pkg::REQ_LOAD_REF, 8'h00, 5'd25, 16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_TEXT,     8'h65, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_SOLVE,    8'h00, 5'd0,  16'h0000, 1'b0, 5'd0},
         '{vkr_pkg::REQ_SOLVE,    8'h00, 5'd0,  16'h0000, 1'b1, 5'd0}   // cleared by solve
      };

      foreach (column_counts[k, j]) column_counts[k][j] = '0;
      foreach (freq_table[j]) freq_table[j] = '0;
      next_column = 0;
      key_length_reg = 6'd1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // frequency table first, so no solve reads an unwritten entry
      for (int j = 0; j < LETTERS; j++)
         send_item(vkr_pkg::REQ_LOAD_REF, 8'h00, 5'(j), 16'(english[j]));

      // directed rows
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_item(rows[i].kind, rows[i].text, rows[i].index, rows[i].value);
         if (rows[i].typed && shifts_due.size() != 0)
            shifts_due[$].shift = rows[i].shift;
      end

      // random phases: enciphered text under a random key, some noise, then solve
      for (int ph = 0; items_sent < TARGET_ITEMS - 40; ph++) begin
         drain();
         write_key_length(ph < 8 ? 6'(plan[ph]) : 6'($urandom_range(0, 63)));
         req_gaps_on = ($urandom_range(0, 3) != 0);
         rsp_stalls_on = ($urandom_range(0, 3) != 0);
         foreach (key_shift[k]) key_shift[k] = $urandom_range(0, 25);
         gen_col = 0;
         text_count = $urandom_range(15, 60);
         shrink_at = ($urandom_range(0, 3) == 0) ? text_count / 2 : -1;
         for (int t = 0; t < text_count; t++) begin
            if (t == shrink_at) begin
               // key no longer than before while letters are already counted
               drain();
               write_key_length(6'($urandom_range(1, columns_in_use())));
            end
            len = columns_in_use();
            p = $urandom_range(0, 9);
            if (p == 0) begin
               send_item(vkr_pkg::REQ_TEXT, 8'($urandom_range(0, 255)), 5'd0, 16'h0000);
            end else if (p == 1 && $urandom_range(0, 2) == 0) begin
               if ($urandom_range(0, 1))
                  send_item(vkr_pkg::REQ_LOAD_REF, 8'h00, 5'($urandom_range(0, 31)),
                            16'($urandom_range(0, 65535)));
               else
                  send_item(vkr_pkg::REQ_NONE, 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
            end else begin
               ch = common_order[$urandom_range(0, 25) < 13 ?
                                 $urandom_range(0, 8) : $urandom_range(0, 25)];
               ch = 8'((ch - vkr_pkg::CHAR_UPPER_A + key_shift[gen_col % len]) % LETTERS);
               ch = ch + ($urandom_range(0, 1) ? vkr_pkg::CHAR_LOWER_A
                                               : vkr_pkg::CHAR_UPPER_A);
               send_item(vkr_pkg::REQ_TEXT, ch, 5'($urandom_range(0, 31)),
                         16'($urandom_range(0, 65535)));
               gen_col++;
            end
         end
         send_item(vkr_pkg::REQ_SOLVE, 8'($urandom_range(0, 255)),
                   5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)));
      end

      drain();
      $display("run covered %0d items, %0d solves and %0d key letters", items_sent,
               solves_sent, results_seen);
      $display("key lengths from 0 to 63, with a shrink while letters were pending");
      if (errors == 0 && shifts_due.size() == 0) begin
         $display("vigenere_key_recovery_unit_tb: done, clean");
      end else begin
         $display("vigenere_key_recovery_unit_tb: done, errors");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hdl/vkr_pkg.sv
hdl/vkr_ram.sv
hdl/vkr_cell.sv
hdl/vigenere_key_recovery_unit.sv
sim/vigenere_key_recovery_unit_tb.sv
